// ===== hdl/itoa_pkg.sv =====
package itoa_pkg;

  localparam int ValueBits = 32;
  localparam int DecDigits = 10;
  localparam int MaxChars  = 11;
  localparam int CntBits   = 4;
  localparam int Stages    = 4;

  typedef enum logic [1:0] {
    KIND_DEC = 2'd0,
    KIND_HEX = 2'd1,
    KIND_OCT = 2'd2,
    KIND_NONE = 2'd3
  } kind_t;

  localparam logic [6:0] CharZero  = 7'h30;
  localparam logic [6:0] CharA     = 7'h61;
  localparam logic [6:0] CharMinus = 7'h2d;

  // character string of one item, most significant first at index 0
  typedef struct packed {
    logic [MaxChars-1:0][6:0] chars;
    logic [CntBits-1:0]       count;
  } run_t;

  function automatic logic [6:0] digit_char(input logic [3:0] d);
    if (d < 4'd10) begin
      return CharZero + {3'd0, d};
    end
    return CharA + {3'd0, d - 4'd10};
  endfunction

endpackage

// ===== hdl/itoa_dec_stage.sv =====
// One double-dabble step row: shift in eight bits of the binary operand.
module itoa_dec_stage (
  input  logic [itoa_pkg::DecDigits*4-1:0] bcd_in,
  input  logic [7:0]                       bits_in,
  output logic [itoa_pkg::DecDigits*4-1:0] bcd_out
);
  import itoa_pkg::*;

  always_comb begin
    logic [DecDigits*4-1:0] b;
    b = bcd_in;
    for (int s = 7; s >= 0; s--) begin
      for (int d = 0; d < DecDigits; d++) begin
        if (b[d*4 +: 4] >= 4'd5) begin
          b[d*4 +: 4] = b[d*4 +: 4] + 4'd3;
        end
      end
      b = {b[DecDigits*4-2:0], bits_in[s]};
    end
    bcd_out = b;
  end
endmodule

// ===== hdl/itoa_serializer.sv =====
// Hold one run and emit its characters one per accepted output cycle.
module itoa_serializer (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   run_valid,
  output logic                   run_stall,
  input  itoa_pkg::run_t         run,
  output logic                   valid,
  input  logic                   stall,
  output logic [6:0]             out_char,
  output logic                   last_char
);
  import itoa_pkg::*;

  run_t               held;
  logic [CntBits-1:0] pos;
  logic               busy;
  logic               done_item;

  assign done_item = valid && !stall && last_char;
  assign run_stall = busy && !done_item;
  assign valid     = busy;
  assign out_char  = held.chars[pos];
  assign last_char = (pos == held.count - CntBits'(1));

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      pos  <= '0;
    end else if (run_valid && !run_stall) begin
      busy <= 1'b1;
      pos  <= '0;
      held <= run;
    end else if (done_item) begin
      busy <= 1'b0;
    end else if (valid && !stall) begin
      pos <= pos + CntBits'(1);
    end
  end
endmodule

// ===== hdl/integer_to_ascii_formatter_core.sv =====
// Path from item accept to first character: an input register, 4 conversion
//   stages, 1 run assembly stage, 1 serializer load.
// Throughput: one character per cycle while out_stall is low; a formatted value
//   gives 1 to 11 characters, and new items are taken while the serializer emits.
// Reset: synchronous rst clears all stage valid bits and the serializer.
module integer_to_ascii_formatter_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  req_type,
  input  logic [31:0] value,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [6:0]  out_char,
  output logic        last_char
);
  import itoa_pkg::*;

  // pipeline registers: stage s has shifted in 8*s operand bits
  logic [Stages:0]                 v;
  logic [Stages:0][1:0]            kind;
  logic [Stages:0]                 neg;
  logic [Stages-1:0][ValueBits-1:0] mag;
  logic [Stages:0][ValueBits-1:0]  raw;
  logic [Stages:0][DecDigits*4-1:0] bcd;
  logic [Stages-1:0][DecDigits*4-1:0] bcd_next;

  logic  adv;
  logic  run_stall;
  run_t  run;
  logic  run_v;

  // the whole pipe advances when the serializer can take its run
  assign adv      = !run_v || !run_stall;
  assign in_stall = !adv;

  for (genvar s = 0; s < Stages; s++) begin : g_dd
    itoa_dec_stage u_stage (
      .bcd_in (bcd[s]),
      .bits_in(mag[s][ValueBits-1-8*s -: 8]),
      .bcd_out(bcd_next[s])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else if (adv) begin
      v[0] <= in_valid && (req_type != KIND_NONE);
      for (int s = 1; s <= Stages; s++) begin
        v[s] <= v[s-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      kind[0] <= req_type;
      raw[0]  <= value;
      neg[0]  <= (req_type == KIND_DEC) && value[ValueBits-1];
      mag[0]  <= (req_type == KIND_DEC && value[ValueBits-1]) ? (~value + 32'd1) : value;
      bcd[0]  <= '0;
      for (int s = 1; s <= Stages; s++) begin
        kind[s] <= kind[s-1];
        raw[s]  <= raw[s-1];
        neg[s]  <= neg[s-1];
        bcd[s]  <= bcd_next[s-1];
      end
      for (int s = 1; s < Stages; s++) begin
        mag[s]  <= mag[s-1];
      end
    end
  end

  // assemble the character run from the final stage
  run_t run_next;
  always_comb begin
    logic [CntBits-1:0] nd;
    logic [CntBits-1:0] k;
    logic [3:0]         d;
    run_next = '0;
    nd = CntBits'(1);
    k  = '0;
    d  = '0;
    unique case (kind[Stages])
      KIND_DEC: begin
        for (int i = 0; i < DecDigits; i++) begin
          if (bcd[Stages][i*4 +: 4] != 4'd0) nd = CntBits'(i + 1);
        end
        if (neg[Stages]) begin
          run_next.chars[0] = CharMinus;
          k = CntBits'(1);
        end
        for (int i = 0; i < DecDigits; i++) begin
          if (CntBits'(i) < nd) begin
            run_next.chars[CntBits'(k + CntBits'(i))] =
              CharZero + {3'd0, bcd[Stages][(nd - 1 - CntBits'(i))*4 +: 4]};
          end
        end
        run_next.count = k + nd;
      end
      KIND_HEX: begin
        for (int i = 0; i < 8; i++) begin
          if (raw[Stages][i*4 +: 4] != 4'd0) nd = CntBits'(i + 1);
        end
        for (int i = 0; i < 8; i++) begin
          if (CntBits'(i) < nd) begin
            d = raw[Stages][(nd - 1 - CntBits'(i))*4 +: 4];
            run_next.chars[i] = digit_char(d);
          end
        end
        run_next.count = nd;
      end
      default: begin
        // full 3-bit groups below bit 30, then the 2-bit top group
        for (int i = 0; i < MaxChars - 1; i++) begin
          if (raw[Stages][i*3 +: 3] != 3'd0) nd = CntBits'(i + 1);
        end
        if (raw[Stages][31:30] != 2'd0) nd = CntBits'(11);
        for (int i = 0; i < MaxChars; i++) begin
          if (CntBits'(i) < nd) begin
            d = (nd - 1 - CntBits'(i) == CntBits'(10)) ? {2'd0, raw[Stages][31:30]}
                : {1'b0, raw[Stages][(nd - 1 - CntBits'(i))*3 +: 3]};
            run_next.chars[i] = digit_char(d);
          end
        end
        run_next.count = nd;
      end
    endcase
  end

  // run assembly register
  always_ff @(posedge clk) begin
    if (rst) begin
      run_v <= 1'b0;
    end else if (adv) begin
      run_v <= v[Stages];
      run   <= run_next;
    end
  end

  itoa_serializer u_ser (
    .clk      (clk),
    .rst      (rst),
    .run_valid(run_v),
    .run_stall(run_stall),
    .run      (run),
    .valid    (out_valid),
    .stall    (out_stall),
    .out_char (out_char),
    .last_char(last_char)
  );
endmodule

// ===== verif/testbench.sv =====
module testbench;
  import itoa_pkg::*;

  logic        clk;
  logic        rst;
  logic        in_valid;
  logic        in_stall;
  logic [1:0]  req_type;
  logic [31:0] value;
  logic        out_valid;
  logic        out_stall;
  logic [6:0]  out_char;
  logic        last_char;

  integer_to_ascii_formatter_core uut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .req_type(req_type), .value(value),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_char(out_char), .last_char(last_char)
  );

  typedef struct packed {
    logic [6:0] ch;
    logic       last;
  } char_exp_t;

  char_exp_t pending_chars[$];
  int        mismatches = 0;
  bit        idle_en = 1;     // random gaps on both sides
  int        hold_cycles = 0; // long receiver hold-off when nonzero

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Push the characters that one item should produce.
  task automatic predict_chars(input logic [1:0] kind, input logic [31:0] v);
    logic [31:0] mag;
    logic [3:0]  digs[$];
    logic [3:0]  d;
    int          top;
    int          grp;
    logic [3:0]  gmask;
    char_exp_t   e;
    if (kind == KIND_NONE) return;
    if (kind == KIND_DEC) begin
      mag = v;
      if (v[31]) begin
        e.ch = CharMinus; e.last = 0; pending_chars.push_back(e);
        mag = ~v + 32'd1;
      end
      do begin
        digs.push_front(4'(mag % 10));
        mag = mag / 10;
      end while (mag != 0);
      foreach (digs[i]) begin
        e.ch = CharZero + {3'd0, digs[i]}; e.last = 0; pending_chars.push_back(e);
      end
    end else begin
      grp = (kind == KIND_HEX) ? 4 : 3;
      gmask = (kind == KIND_HEX) ? 4'hf : 4'h7;
      top = (31 / grp) * grp;
      while (top > 0 && ((v >> top) & gmask) == 0) top -= grp;
      while (top >= 0) begin
        d = 4'((v >> top) & gmask);
        e.ch = (d < 10) ? CharZero + {3'd0, d} : CharA + {3'd0, d - 4'd10};
        e.last = 0;
        pending_chars.push_back(e);
        top -= grp;
      end
    end
    pending_chars[pending_chars.size() - 1].last = 1;
  endtask

  // Offer one item and hold it until accepted; drop valid only for a gap.
  task automatic send_item(input logic [1:0] kind, input logic [31:0] v);
    int gap;
    if (idle_en && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 9);
      in_valid <= 0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1; req_type <= kind; value <= v;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predict_chars(kind, v);
    @(negedge clk);
  endtask

  task automatic wait_drained();
    in_valid <= 0;
    while (pending_chars.size() != 0) @(negedge clk);
    repeat (12) @(negedge clk);
  endtask

  // Receiver stall: random bursts, or one long hold-off on request.
  initial begin
    int n;
    out_stall = 0;
    forever begin
      @(negedge clk);
      if (hold_cycles > 0) begin
        out_stall <= 1;
        repeat (hold_cycles) @(negedge clk);
        hold_cycles = 0;
        out_stall <= 0;
      end else if (idle_en && $urandom_range(0, 5) == 0) begin
        n = $urandom_range(1, 9);
        out_stall <= 1;
        repeat (n) @(negedge clk);
        out_stall <= 0;
      end
    end
  end

  // Compare each accepted character with the oldest expectation.
  always @(posedge clk) begin
    char_exp_t e;
    if (!rst && out_valid && !out_stall) begin
      if (pending_chars.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected char %h last %b", out_char, last_char);
      end else begin
        e = pending_chars.pop_front();
        if (e.ch !== out_char || e.last !== last_char) begin
          mismatches++;
          if (mismatches <= 10)
            $display("char mismatch: exp %h/%b got %h/%b", e.ch, e.last, out_char, last_char);
        end
      end
    end
  end

  task automatic test_directed();
    send_item(KIND_DEC, 32'd0);
    send_item(KIND_DEC, 32'd7);
    send_item(KIND_DEC, 32'hffffffff);
    send_item(KIND_DEC, 32'h80000000);
    send_item(KIND_DEC, 32'h7fffffff);
    send_item(KIND_DEC, 32'd1000000000);
    send_item(KIND_HEX, 32'd0);
    send_item(KIND_HEX, 32'hffffffff);
    send_item(KIND_HEX, 32'h0000abcd);
    send_item(KIND_HEX, 32'h10000000);
    send_item(KIND_OCT, 32'd0);
    send_item(KIND_OCT, 32'hffffffff);
    send_item(KIND_OCT, 32'h40000000);
    send_item(KIND_OCT, 32'h00000008);
    send_item(KIND_NONE, 32'h12345678);
    send_item(KIND_NONE, 32'hffffffff);
    send_item(KIND_HEX, 32'h00000001);
  endtask

  function automatic logic [31:0] rand_value();
    case ($urandom_range(0, 3))
      0: return $urandom;
      1: return $urandom_range(0, 1000);
      2: return 32'hffffffff - $urandom_range(0, 1000);
      default: return $urandom >> $urandom_range(0, 31);
    endcase
  endfunction

  task automatic test_random(input int n);
    logic [1:0] k;
    repeat (n) begin
      k = ($urandom_range(0, 19) == 0) ? KIND_NONE : 2'($urandom_range(0, 2));
      send_item(k, rand_value());
    end
  endtask

  // Hold the receiver while items keep coming, so the input backs up.
  task automatic test_backpressure();
    hold_cycles = 150;
    test_random(20);
    wait_drained();
  endtask

  initial begin
    rst = 1; in_valid = 0; req_type = 0; value = 0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst = 0;
    test_directed();
    wait_drained();
    test_random(200);
    test_backpressure();
    idle_en = 0;
    test_random(70);
    wait_drained();
    if (mismatches == 0 && pending_chars.size() == 0)
      $display("PASS integer_to_ascii_formatter_core");
    else
      $display("FAIL integer_to_ascii_formatter_core");
    $finish;
  end

  initial begin
    #2000000;
    $display("FAIL integer_to_ascii_formatter_core");
    $finish;
  end

endmodule

// ===== integer_to_ascii_formatter_core.f =====
hdl/itoa_pkg.sv
hdl/itoa_dec_stage.sv
hdl/itoa_serializer.sv
hdl/integer_to_ascii_formatter_core.sv
verif/testbench.sv
